[src/i2crts_pkg.sv]
// shared constants and types for the i2c register transaction sequencer
`default_nettype none
package i2crts_pkg;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [7:0] READ_BIT = 8'h01;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_EVENT = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [6:0] device_address;
      logic [7:0] register_address;
      logic       read_access;
      logic [7:0] byte_count;
      logic       nack_received;
      logic [7:0] received_byte;
      logic [7:0] next_write_byte;
   } req_type;

   typedef struct packed {
      logic       load_byte_valid;
      logic [7:0] load_byte;
      logic       repeated_start;
      logic       transmit_direction;
      logic       master_hold;
      logic       nack_next;
      logic       dummy_read;
      logic       write_byte_taken;
      logic       stored_byte_valid;
      logic [7:0] stored_index;
      logic [1:0] status;
   } rsp_type;

endpackage
`default_nettype wire

[src/i2c_register_transaction_sequencer_top.sv]
// top level of the i2c register transaction sequencer
//
//  channel | ports                  | moves
//  --------+------------------------+-------------------------------------
//  req     | req_tvalid/tready/tdata/tuser | start request or byte-complete event
//  rsp     | rsp_tvalid/tready/tdata | one decision per request
//
//  one request per cycle unless rsp stalls; path: input register, then result register
//  the transaction state is updated as a request moves into the result register
//  a stalled result holds the result register and, once the input register is full, req_tready
//  reset is synchronous, active high, and returns the sequencer to done with no transaction
`default_nettype none
module i2c_register_transaction_sequencer_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // device_address[6:0], register_address[14:7], read_access[15], byte_count[23:16],
   // nack_received[24], received_byte[32:25], next_write_byte[40:33], zero[47:41]
   input  wire logic [i2crts_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[0]
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // load_byte_valid[0], load_byte[8:1], repeated_start[9], transmit_direction[10],
   // master_hold[11], nack_next[12], dummy_read[13], write_byte_taken[14],
   // stored_byte_valid[15], stored_index[23:16], status[25:24], zero[31:26]
   output logic [i2crts_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   // input register
   logic                in_valid_ff;
   i2crts_pkg::req_type in_req_ff;
   // result register
   logic                out_valid_ff;
   i2crts_pkg::rsp_type out_rsp_ff, out_rsp_in;

   // transaction state
   logic [1:0] phase_status_ff, phase_status_in;
   logic [6:0] target_address_ff, target_address_in;
   logic [7:0] target_register_ff, target_register_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] total_bytes_ff, total_bytes_in;
   logic [7:0] byte_position_ff, byte_position_in;
   logic       register_sent_ff, register_sent_in;
   logic       restart_sent_ff, restart_sent_in;
   logic       direction_is_tx_ff, direction_is_tx_in;

   logic advance;
   logic [8:0] last_pos;
   logic [8:0] pos_plus_two;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_req_ff.mode             <= req_tuser;
         in_req_ff.device_address   <= req_tdata[6:0];
         in_req_ff.register_address <= req_tdata[14:7];
         in_req_ff.read_access      <= req_tdata[15];
         in_req_ff.byte_count       <= req_tdata[23:16];
         in_req_ff.nack_received    <= req_tdata[24];
         in_req_ff.received_byte    <= req_tdata[32:25];
         in_req_ff.next_write_byte  <= req_tdata[40:33];
      end
   end

   assign last_pos     = {1'b0, total_bytes_ff} - 9'd1;
   assign pos_plus_two = {1'b0, byte_position_ff} + 9'd2;

   always_comb begin
      phase_status_in    = phase_status_ff;
      target_address_in  = target_address_ff;
      target_register_in = target_register_ff;
      is_read_in         = is_read_ff;
      total_bytes_in     = total_bytes_ff;
      byte_position_in   = byte_position_ff;
      register_sent_in   = register_sent_ff;
      restart_sent_in    = restart_sent_ff;
      direction_is_tx_in = direction_is_tx_ff;
      out_rsp_in         = '0;

      if (in_req_ff.mode == i2crts_pkg::MODE_START) begin
         if (in_req_ff.byte_count != 8'd0 && phase_status_ff != i2crts_pkg::ST_BUSY) begin
            phase_status_in            = i2crts_pkg::ST_BUSY;
            target_address_in          = in_req_ff.device_address;
            target_register_in         = in_req_ff.register_address;
            is_read_in                 = in_req_ff.read_access;
            total_bytes_in             = in_req_ff.byte_count;
            byte_position_in           = 8'd0;
            register_sent_in           = 1'b0;
            restart_sent_in            = 1'b0;
            direction_is_tx_in         = 1'b1;
            out_rsp_in.load_byte_valid = 1'b1;
            out_rsp_in.load_byte       = {in_req_ff.device_address, 1'b0};
         end
      end else if (phase_status_ff == i2crts_pkg::ST_BUSY) begin
         if (direction_is_tx_ff) begin
            if (!is_read_ff) begin
               if (byte_position_ff < total_bytes_ff) begin
                  if (in_req_ff.nack_received) begin
                     phase_status_in = i2crts_pkg::ST_ERROR;
                  end else if (register_sent_ff) begin
                     out_rsp_in.load_byte_valid  = 1'b1;
                     out_rsp_in.load_byte        = in_req_ff.next_write_byte;
                     out_rsp_in.write_byte_taken = 1'b1;
                     byte_position_in            = byte_position_ff + 8'd1;
                  end else begin
                     out_rsp_in.load_byte_valid = 1'b1;
                     out_rsp_in.load_byte       = target_register_ff;
                     register_sent_in           = 1'b1;
                  end
               end else begin
                  phase_status_in = i2crts_pkg::ST_DONE;
               end
            end else begin
               if (in_req_ff.nack_received) begin
                  phase_status_in = i2crts_pkg::ST_ERROR;
               end else if (!register_sent_ff) begin
                  out_rsp_in.load_byte_valid = 1'b1;
                  out_rsp_in.load_byte       = target_register_ff;
                  register_sent_in           = 1'b1;
               end else if (!restart_sent_ff) begin
                  out_rsp_in.repeated_start  = 1'b1;
                  out_rsp_in.load_byte_valid = 1'b1;
                  out_rsp_in.load_byte       = {target_address_ff, 1'b0} | i2crts_pkg::READ_BIT;
                  restart_sent_in            = 1'b1;
               end else begin
                  direction_is_tx_in    = 1'b0;
                  out_rsp_in.nack_next  = (total_bytes_ff == 8'd1);
                  out_rsp_in.dummy_read = 1'b1;
               end
            end
         end else begin
            if ({1'b0, byte_position_ff} == last_pos) begin
               direction_is_tx_in           = 1'b1;
               out_rsp_in.stored_byte_valid = 1'b1;
               out_rsp_in.stored_index      = byte_position_ff;
               byte_position_in             = byte_position_ff + 8'd1;
               phase_status_in              = i2crts_pkg::ST_DONE;
            end else if (total_bytes_ff != 8'd0 && {1'b0, byte_position_ff} < last_pos) begin
               out_rsp_in.nack_next         = (pos_plus_two == {1'b0, total_bytes_ff});
               out_rsp_in.stored_byte_valid = 1'b1;
               out_rsp_in.stored_index      = byte_position_ff;
               byte_position_in             = byte_position_ff + 8'd1;
            end
         end
      end

      out_rsp_in.transmit_direction = direction_is_tx_in;
      out_rsp_in.master_hold        = (phase_status_in == i2crts_pkg::ST_BUSY);
      out_rsp_in.status             = phase_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff       <= 1'b0;
         phase_status_ff    <= i2crts_pkg::ST_DONE;
         target_address_ff  <= '0;
         target_register_ff <= '0;
         is_read_ff         <= 1'b0;
         total_bytes_ff     <= '0;
         byte_position_ff   <= '0;
         register_sent_ff   <= 1'b0;
         restart_sent_ff    <= 1'b0;
         direction_is_tx_ff <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff       <= 1'b1;
            phase_status_ff    <= phase_status_in;
            target_address_ff  <= target_address_in;
            target_register_ff <= target_register_in;
            is_read_ff         <= is_read_in;
            total_bytes_ff     <= total_bytes_in;
            byte_position_ff   <= byte_position_in;
            register_sent_ff   <= register_sent_in;
            restart_sent_ff    <= restart_sent_in;
            direction_is_tx_ff <= direction_is_tx_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0,
                        out_rsp_ff.status,
                        out_rsp_ff.stored_index,
                        out_rsp_ff.stored_byte_valid,
                        out_rsp_ff.write_byte_taken,
                        out_rsp_ff.dummy_read,
                        out_rsp_ff.nack_next,
                        out_rsp_ff.master_hold,
                        out_rsp_ff.transmit_direction,
                        out_rsp_ff.repeated_start,
                        out_rsp_ff.load_byte,
                        out_rsp_ff.load_byte_valid};

endmodule
`default_nettype wire
